>>> rtl/sha_pkg.sv
`default_nettype none
package sha_pkg;

	localparam int unsigned Rounds = 64;

	// Block handed from the front end to the compression engine.
	typedef struct packed {
		logic [511:0] block;  // byte 0 in bits 511:504
		logic         final_blk;
	} blk_t;

	localparam logic [7:0] PadByte = 8'h80;

	localparam logic [31:0] HashInit [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] ror(input logic [31:0] v, input int unsigned n);
		ror = (v >> n) | (v << (32 - n));
	endfunction

endpackage
`default_nettype wire

>>> rtl/sha_front.sv
`default_nettype none
// Collects bytes into a block, applies padding on finish, and pushes blocks.
module sha_front (
	input  wire  logic         clk,
	input  wire  logic         arst_n,
	input  wire  logic         in_valid,
	output logic               in_ready,
	input  wire  logic         func,
	input  wire  logic [7:0]   data_byte,
	output logic               blk_valid,
	input  wire  logic         blk_ready,
	output sha_pkg::blk_t      blk
);
	typedef enum logic [2:0] {
		S_FILL = 3'b001,
		S_PAD  = 3'b010,
		S_PUSH = 3'b100
	} fst_t;

	fst_t          st_q;
	logic [511:0]  buf_q;
	logic [5:0]    fill_q;
	logic [63:0]   bits_q;
	logic          fin_q;     // padding in progress
	logic          lenok_q;   // this pad block carries the length
	logic          last_q;    // block being pushed ends the message

	assign in_ready = (st_q == S_FILL);
	assign blk_valid = (st_q == S_PUSH);
	assign blk.block = buf_q;
	assign blk.final_blk = last_q;

	function automatic logic [511:0] put(input logic [511:0] b, input logic [5:0] i,
			input logic [7:0] v);
		logic [511:0] r;
		r = b;
		r[(6'd63 - i) * 8 +: 8] = v;
		put = r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_FILL;
			fill_q <= '0;
			bits_q <= '0;
			fin_q <= 1'b0;
			lenok_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			unique case (st_q)
				S_FILL: begin
					if (in_valid) begin
						if (!func) begin
							buf_q <= put(buf_q, fill_q, data_byte);
							bits_q <= bits_q + 64'd8;
							fill_q <= fill_q + 6'd1;
							last_q <= 1'b0;
							if (fill_q == 6'd63) st_q <= S_PUSH;
						end else begin
							buf_q <= put(buf_q, fill_q, sha_pkg::PadByte);
							fill_q <= fill_q + 6'd1;
							fin_q <= 1'b1;
							lenok_q <= (fill_q < 6'd56);
							if (fill_q == 6'd63) begin
								last_q <= 1'b0;
								st_q <= S_PUSH;
							end else begin
								st_q <= S_PAD;
							end
						end
					end
				end
				S_PAD: begin
					if (lenok_q && fill_q == 6'd56) begin
						buf_q[63:0] <= bits_q;
						fill_q <= '0;
						last_q <= 1'b1;
						st_q <= S_PUSH;
					end else begin
						buf_q <= put(buf_q, fill_q, 8'h00);
						fill_q <= fill_q + 6'd1;
						if (fill_q == 6'd63) begin
							last_q <= 1'b0;
							st_q <= S_PUSH;
						end
					end
				end
				S_PUSH: begin
					if (blk_ready) begin
						if (fin_q && !last_q) begin
							lenok_q <= 1'b1;
							st_q <= S_PAD;
						end else begin
							st_q <= S_FILL;
							if (last_q) begin
								fin_q <= 1'b0;
								bits_q <= '0;
							end
						end
					end
				end
				default: st_q <= S_FILL;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> rtl/sha_queue.sv
`default_nettype none
// Two-entry block queue between front end and engine.
module sha_queue (
	input  wire  logic    clk,
	input  wire  logic    arst_n,
	input  wire  logic    wr_valid,
	output logic          wr_ready,
	input  sha_pkg::blk_t wr_data,
	output logic          rd_valid,
	input  wire  logic    rd_ready,
	output sha_pkg::blk_t rd_data
);
	sha_pkg::blk_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_valid && wr_ready) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr_valid && wr_ready) wp_q <= ~wp_q;
			if (rd_valid && rd_ready) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'((wr_valid && wr_ready) ? 1 : 0)
				- 2'((rd_valid && rd_ready) ? 1 : 0);
		end
	end
endmodule
`default_nettype wire

>>> rtl/sha_engine.sv
`default_nettype none
// One round per cycle compression; emits the digest after a final block.
module sha_engine (
	input  wire  logic        clk,
	input  wire  logic        arst_n,
	input  wire  logic        blk_valid,
	output logic              blk_ready,
	input  sha_pkg::blk_t     blk,
	output logic              out_valid,
	input  wire  logic        out_ready,
	output logic [31:0]       digest_word,
	output logic [2:0]        word_index,
	output logic              last
);
	typedef enum logic [3:0] {
		E_IDLE = 4'b0001,
		E_RUN  = 4'b0010,
		E_ADD  = 4'b0100,
		E_OUT  = 4'b1000
	} est_t;

	est_t        st_q;
	logic [31:0] h_q [8];
	logic [31:0] s_q [8];
	logic [31:0] w_q [16];   // sliding message schedule window
	logic [5:0]  rnd_q;
	logic [2:0]  oidx_q;
	logic        fin_q;

	logic [31:0] wn, t1, t2, a, e, x, y;

	always_comb begin
		x = w_q[1];
		y = w_q[14];
		wn = w_q[0] + w_q[9]
			+ (sha_pkg::ror(x, 7) ^ sha_pkg::ror(x, 18) ^ (x >> 3))
			+ (sha_pkg::ror(y, 17) ^ sha_pkg::ror(y, 19) ^ (y >> 10));
		a = s_q[0];
		e = s_q[4];
		t1 = s_q[7] + (sha_pkg::ror(e, 6) ^ sha_pkg::ror(e, 11) ^ sha_pkg::ror(e, 25))
			+ ((e & s_q[5]) ^ (~e & s_q[6])) + sha_pkg::RoundK[rnd_q] + w_q[0];
		t2 = (sha_pkg::ror(a, 2) ^ sha_pkg::ror(a, 13) ^ sha_pkg::ror(a, 22))
			+ ((a & s_q[1]) ^ (a & s_q[2]) ^ (s_q[1] & s_q[2]));
	end

	assign blk_ready = (st_q == E_IDLE);
	assign out_valid = (st_q == E_OUT);
	assign digest_word = h_q[oidx_q];
	assign word_index = oidx_q;
	assign last = (oidx_q == 3'd7);

	always_ff @(posedge clk) begin
		if (st_q == E_IDLE && blk_valid) begin
			for (int i = 0; i < 16; i++) w_q[i] <= blk.block[511 - 32 * i -: 32];
			for (int i = 0; i < 8; i++) s_q[i] <= h_q[i];
		end else if (st_q == E_RUN) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
			w_q[15] <= wn;
			s_q[7] <= s_q[6];
			s_q[6] <= s_q[5];
			s_q[5] <= e;
			s_q[4] <= s_q[3] + t1;
			s_q[3] <= s_q[2];
			s_q[2] <= s_q[1];
			s_q[1] <= a;
			s_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= E_IDLE;
			rnd_q <= '0;
			oidx_q <= '0;
			fin_q <= 1'b0;
			for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::HashInit[i];
		end else begin
			unique case (st_q)
				E_IDLE: if (blk_valid) begin
					fin_q <= blk.final_blk;
					rnd_q <= '0;
					st_q <= E_RUN;
				end
				E_RUN: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'(sha_pkg::Rounds - 1)) st_q <= E_ADD;
				end
				E_ADD: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + s_q[i];
					oidx_q <= '0;
					st_q <= fin_q ? E_OUT : E_IDLE;
				end
				E_OUT: if (out_ready) begin
					oidx_q <= oidx_q + 3'd1;
					if (oidx_q == 3'd7) begin
						for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::HashInit[i];
						st_q <= E_IDLE;
					end
				end
				default: st_q <= E_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> rtl/sha256_message_hasher.sv
`default_nettype none
// Channel   Direction  Fields (tdata low bit up)           tuser   tlast
// s_axis    in         data_byte[7:0]                      func    -
// m_axis    out        digest_word[31:0], word_index[34:32] -       last
//
// A byte item is taken while the front end is filling; every 64th byte
// hands a block to a two-entry queue. The engine runs the rounds of a
// block, then adds the hash words; it takes a new block only when idle,
// while the queue lets the front end fill more. A finish item pads the
// message, then the eight digest words follow. Reset loads the initial
// hash values; a stalled output holds the engine and, once the queue is full, input.
module sha256_message_hasher (
	input  wire  logic        clk,
	input  wire  logic        arst_n,
	input  wire  logic        s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire  logic [7:0]  s_axis_tdata,   // data_byte
	input  wire  logic        s_axis_tuser,   // func
	output logic              m_axis_tvalid,
	input  wire  logic        m_axis_tready,
	output logic [39:0]       m_axis_tdata,   // digest_word, word_index, zero fill
	output logic              m_axis_tlast    // last
);
	logic          f_valid, f_ready, q_valid, q_ready;
	sha_pkg::blk_t f_blk, q_blk;
	logic [31:0]   dw;
	logic [2:0]    wi;

	sha_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.func(s_axis_tuser), .data_byte(s_axis_tdata),
		.blk_valid(f_valid), .blk_ready(f_ready), .blk(f_blk)
	);

	sha_queue u_queue (
		.clk, .arst_n,
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_blk),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_blk)
	);

	sha_engine u_engine (
		.clk, .arst_n,
		.blk_valid(q_valid), .blk_ready(q_ready), .blk(q_blk),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.digest_word(dw), .word_index(wi), .last(m_axis_tlast)
	);

	assign m_axis_tdata = {5'd0, wi, dw};
endmodule
`default_nettype wire

>>> rtl/sha_checker.sv
`default_nettype none
module sha_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [39:0] m_axis_tdata,
	input wire logic        m_axis_tlast
);
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[34:32] == 3'd7)))
		else $error("tlast does not match word index");
	a_next_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
		(m_axis_tvalid && m_axis_tdata[34:32] == $past(m_axis_tdata[34:32]) + 3'd1))
		else $error("digest words not contiguous");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled output changed");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[39:35] == 5'd0)
		else $error("fill bits not zero");
	a_in_ready_known: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid |-> !$isunknown(s_axis_tready))
		else $error("input ready unknown while an item is offered");
endmodule

bind sha256_message_hasher sha_checker u_sha_checker (
	.clk, .arst_n, .s_axis_tvalid, .s_axis_tready,
	.m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
);
`default_nettype wire
